>>> rtl/plids_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Transfer types, request codes and per-cell control used across the list.
// ----------------------------------------------------------------------------
package plids_pkg;

	// Request codes.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_LOCATE = 2'd2;

	// Number of match bits that one first-match encoder covers.
	localparam int GROUP_SIZE = 16;

	// One request transfer.
	typedef struct packed {
		logic [1:0]         req_type;
		logic [7:0]         position;
		logic signed [31:0] value;
	} req_t;

	// One result transfer.
	typedef struct packed {
		logic       ok;
		logic [7:0] found_position;
		logic [7:0] list_length;
	} rsp_t;

	// Per-cell control for one request.
	typedef struct packed {
		logic load;       // take the broadcast value
		logic from_left;  // take the lower neighbor's entry
		logic from_right; // take the upper neighbor's entry
		logic compare;    // compare the held entry with the broadcast value
	} cell_cmd_t;

endpackage

>>> rtl/plids_cell.sv
// ----------------------------------------------------------------------------
// Positional list cell
// Holds one list entry, shifts with its neighbors and compares for locate.
// ----------------------------------------------------------------------------
module plids_cell (
	input  logic                 clk,
	input  plids_pkg::cell_cmd_t cmd,
	input  logic signed [31:0]   value,
	input  logic signed [31:0]   left_data,
	input  logic signed [31:0]   right_data,
	output logic signed [31:0]   data,
	output logic                 match
);

	logic signed [31:0] entry_q;
	logic               match_q;

	// Entry update: load, shift up from below or shift down from above.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			entry_q <= value;
		end else if (cmd.from_left) begin
			entry_q <= left_data;
		end else if (cmd.from_right) begin
			entry_q <= right_data;
		end
	end

	// Registered compare against the entry held before this request.
	always_ff @(posedge clk) begin
		match_q <= cmd.compare && (entry_q == value);
	end

	assign data  = entry_q;
	assign match = match_q;

endmodule

>>> rtl/plids_first.sv
// ----------------------------------------------------------------------------
// Positional list first-match encoder
// Finds the lowest set bit of a small vector and reports its index.
// ----------------------------------------------------------------------------
module plids_first #(
	parameter int N = 16
) (
	input  logic [N-1:0]                    bits,
	output logic                            hit,
	output logic [((N > 1) ? $clog2(N) : 1)-1:0] idx
);

	localparam int IW = (N > 1) ? $clog2(N) : 1;

	// Scan from the top so that the lowest set bit wins.
	always_comb begin
		idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (bits[i]) begin
				idx = IW'(i);
			end
		end
	end

	assign hit = |bits;

endmodule

>>> rtl/positional_list_insert_delete_search_top.sv
// ----------------------------------------------------------------------------
// Positional list with insert, delete and locate
// Bounded ordered list held in a row of shift cells with parallel compare.
// ----------------------------------------------------------------------------
// Usage:
// A request transfer (req_valid high, req_stall low) carries a request type,
// a 1-based position and a value. Insert places the value at the position and
// moves later entries up; delete removes the entry and moves later entries
// down; locate returns the lowest position holding the value, or 0.
// Each request gives exactly one result transfer on rsp: ok, found_position
// and the list length after the request.
// One request is in flight at a time, so the block takes no new request
// until the last one has left its final stage: the cells update or compare
// first, the registered match bits are reduced by a group encoder, whose
// outputs are registered, and then by a final encoder, and the result is
// registered. req_stall is high while a request is in flight.
// If the receiver stalls, the result stays on rsp and the next request may
// be taken and worked on; it waits in the last stage until rsp is free.
// Reset empties the list; entry contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_search_top #(
	parameter int CAPACITY = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  plids_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output plids_pkg::rsp_t rsp
);

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int XW  = ((CW > 8) ? CW : 8) + 1;
	localparam int GS  = plids_pkg::GROUP_SIZE;
	localparam int GW  = $clog2(GS);
	localparam int NG  = (CAPACITY + GS - 1) / GS;
	localparam int FW  = (NG > 1) ? $clog2(NG) : 1;

	// Pipeline registers.
	logic            valid_s1, valid_s2, valid_s3;
	plids_pkg::req_t req_s1;
	logic [CW-1:0]   count_q;
	logic            locate_s2, ok_s2;
	logic [7:0]      len_s2;
	logic            locate_s3, ok_s3;
	logic [7:0]      len_s3;
	logic [NG-1:0]   grp_hit_s3;
	logic [GW-1:0]   grp_idx_s3 [NG];
	logic            rsp_valid_q;
	plids_pkg::rsp_t rsp_q;

	// Request decode.
	logic [XW-1:0] pos_x, pos0_x, cnt_x;
	logic          ins_ok, del_ok, is_locate;
	logic [CW-1:0] count_next;
	logic          accept, advance;

	// Cell row signals.
	logic signed [31:0]   cell_data [CAPACITY];
	logic [NG*GS-1:0]     match_vec;
	logic [NG-1:0]        grp_hit;
	logic [GW-1:0]        grp_idx [NG];
	logic                 fin_hit;
	logic [FW-1:0]        fin_idx;
	logic [XW-1:0]        found_x;

	assign accept    = req_valid && !req_stall;
	assign req_stall = valid_s1 || valid_s2 || valid_s3;
	assign advance   = valid_s3 && (!rsp_valid_q || !rsp_stall);

	// Bound checks on the request in the cell stage.
	always_comb begin
		pos_x     = XW'(req_s1.position);
		pos0_x    = pos_x - XW'(1);
		cnt_x     = XW'(count_q);
		is_locate = valid_s1 && (req_s1.req_type == plids_pkg::REQ_LOCATE);
		ins_ok    = valid_s1 && (req_s1.req_type == plids_pkg::REQ_INSERT)
			&& (pos_x != '0) && (pos_x <= cnt_x + XW'(1))
			&& (cnt_x < XW'(CAPACITY));
		del_ok    = valid_s1 && (req_s1.req_type == plids_pkg::REQ_DELETE)
			&& (pos_x != '0) && (pos_x <= cnt_x);
		if (ins_ok) begin
			count_next = count_q + CW'(1);
		end else if (del_ok) begin
			count_next = count_q - CW'(1);
		end else begin
			count_next = count_q;
		end
	end

	// Row of cells; each decides its move from its place against the position.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		plids_pkg::cell_cmd_t cmd;
		logic signed [31:0]   left_d, right_d;

		always_comb begin
			cmd.load       = ins_ok && (XW'(i) == pos0_x);
			cmd.from_left  = ins_ok && (XW'(i) > pos0_x);
			cmd.from_right = del_ok && (XW'(i) >= pos0_x);
			cmd.compare    = is_locate && (XW'(i) < cnt_x);
		end

		if (i == 0) begin : g_lo
			assign left_d = '0;
		end else begin : g_lo_n
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_hi
			assign right_d = '0;
		end else begin : g_hi_n
			assign right_d = cell_data[i+1];
		end

		plids_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.value      (req_s1.value),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.match      (match_vec[i])
		);
	end

	// Pad the match vector up to whole groups.
	if (NG * GS > CAPACITY) begin : g_pad
		assign match_vec[NG*GS-1:CAPACITY] = '0;
	end

	// First match within each group.
	for (genvar g = 0; g < NG; g++) begin : g_grp
		plids_first #(.N(GS)) u_first (
			.bits (match_vec[g*GS +: GS]),
			.hit  (grp_hit[g]),
			.idx  (grp_idx[g])
		);
	end

	// First group with a match.
	plids_first #(.N(NG)) u_final (
		.bits (grp_hit_s3),
		.hit  (fin_hit),
		.idx  (fin_idx)
	);

	assign found_x = XW'({fin_idx, grp_idx_s3[fin_idx]}) + XW'(1);

	// Control and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 || (valid_s3 && !advance);
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (valid_s1) begin
				count_q <= count_next;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (valid_s1) begin
			locate_s2 <= is_locate;
			ok_s2     <= ins_ok || del_ok;
			len_s2    <= 8'(XW'(count_next));
		end
		if (valid_s2) begin
			locate_s3  <= locate_s2;
			ok_s3      <= ok_s2;
			len_s3     <= len_s2;
			grp_hit_s3 <= grp_hit;
			for (int g = 0; g < NG; g++) begin
				grp_idx_s3[g] <= grp_idx[g];
			end
		end
		if (advance) begin
			rsp_q.ok             <= locate_s3 ? fin_hit : ok_s3;
			rsp_q.found_position <= (locate_s3 && fin_hit) ? found_x[7:0] : 8'd0;
			rsp_q.list_length    <= len_s3;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Positional list testbench
// Sends insert, delete and locate requests through the valid/stall channels
// and checks every result against a local model of the ordered list. A short
// table of directed requests comes first, then random request streams that
// fill the list to capacity and drain it again.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_CAP = 128;
	localparam int RANDOM_REQUESTS = 1075;

	// Request code that the block leaves unused.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Marks whether a table row carries a written-out result.
	localparam logic TYPED = 1'b1;
	localparam logic PREDICT = 1'b0;

	// One row of the directed table.
	typedef struct packed {
		plids_pkg::req_t item;
		logic            typed;
		plids_pkg::rsp_t want;
	} row_t;

	// Directed requests, starting from an empty list.
	localparam row_t DIRECTED_ROWS [26] = '{
		// Empty list: locate misses, delete and bad inserts are refused.
		{plids_pkg::REQ_LOCATE, 8'd0,   32'h0000_0000, TYPED,   1'b0, 8'd0, 8'd0},
		{plids_pkg::REQ_DELETE, 8'd1,   32'h0000_0000, TYPED,   1'b0, 8'd0, 8'd0},
		{plids_pkg::REQ_INSERT, 8'd0,   32'h0000_0001, TYPED,   1'b0, 8'd0, 8'd0},
		{plids_pkg::REQ_INSERT, 8'd2,   32'h0000_0002, TYPED,   1'b0, 8'd0, 8'd0},
		// Build the list 0, 0, min, max, -1 with front, middle and end inserts.
		{plids_pkg::REQ_INSERT, 8'd1,   32'h8000_0000, TYPED,   1'b1, 8'd0, 8'd1},
		{plids_pkg::REQ_INSERT, 8'd2,   32'h7FFF_FFFF, TYPED,   1'b1, 8'd0, 8'd2},
		{plids_pkg::REQ_INSERT, 8'd1,   32'h0000_0000, TYPED,   1'b1, 8'd0, 8'd3},
		{plids_pkg::REQ_INSERT, 8'd4,   32'hFFFF_FFFF, TYPED,   1'b1, 8'd0, 8'd4},
		{plids_pkg::REQ_INSERT, 8'd2,   32'h0000_0000, TYPED,   1'b1, 8'd0, 8'd5},
		// Locates: duplicate gives the lowest position, position is ignored.
		{plids_pkg::REQ_LOCATE, 8'd255, 32'h0000_0000, TYPED,   1'b1, 8'd1, 8'd5},
		{plids_pkg::REQ_LOCATE, 8'd0,   32'hFFFF_FFFF, TYPED,   1'b1, 8'd5, 8'd5},
		{plids_pkg::REQ_LOCATE, 8'd3,   32'h8000_0000, TYPED,   1'b1, 8'd3, 8'd5},
		{plids_pkg::REQ_LOCATE, 8'd0,   32'h0000_007B, TYPED,   1'b0, 8'd0, 8'd5},
		// Out-of-range inserts and deletes, including one past the end.
		{plids_pkg::REQ_INSERT, 8'd255, 32'h0000_0005, TYPED,   1'b0, 8'd0, 8'd5},
		{plids_pkg::REQ_INSERT, 8'd7,   32'h0000_0005, TYPED,   1'b0, 8'd0, 8'd5},
		{plids_pkg::REQ_DELETE, 8'd0,   32'h0000_0000, TYPED,   1'b0, 8'd0, 8'd5},
		{plids_pkg::REQ_DELETE, 8'd6,   32'h0000_0000, TYPED,   1'b0, 8'd0, 8'd5},
		{plids_pkg::REQ_DELETE, 8'd255, 32'h0000_0000, TYPED,   1'b0, 8'd0, 8'd5},
		// The unused request code changes nothing.
		{REQ_UNUSED,            8'd1,   32'h0000_0005, TYPED,   1'b0, 8'd0, 8'd5},
		// Delete the front and the end entries.
		{plids_pkg::REQ_DELETE, 8'd1,   32'h0000_0000, TYPED,   1'b1, 8'd0, 8'd4},
		{plids_pkg::REQ_LOCATE, 8'd0,   32'h0000_0000, TYPED,   1'b1, 8'd1, 8'd4},
		{plids_pkg::REQ_DELETE, 8'd4,   32'h0000_0000, TYPED,   1'b1, 8'd0, 8'd3},
		{plids_pkg::REQ_LOCATE, 8'd0,   32'hFFFF_FFFF, TYPED,   1'b0, 8'd0, 8'd3},
		// Mixed traffic left to the model.
		{plids_pkg::REQ_INSERT, 8'd2,   32'h5555_5555, PREDICT, 1'b0, 8'd0, 8'd0},
		{plids_pkg::REQ_DELETE, 8'd2,   32'hAAAA_AAAA, PREDICT, 1'b0, 8'd0, 8'd0},
		{plids_pkg::REQ_LOCATE, 8'd0,   32'h7FFF_FFFF, PREDICT, 1'b0, 8'd0, 8'd0}
	};

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	plids_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	plids_pkg::rsp_t rsp;

	// Model of the list contents and length.
	logic signed [31:0] held_entries [LIST_CAP];
	int held_count;
	bit growing;

	plids_pkg::rsp_t pending_results [$];
	int errors;
	int cycle_no;

	positional_list_insert_delete_search_top #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Clock with a 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
	end

	// Both sides stop idling inside this window.
	function automatic bit steady_window();
		return cycle_no >= 3000 && cycle_no < 4200;
	endfunction

	// Apply one request to the list model and return its result.
	function automatic plids_pkg::rsp_t apply_request(plids_pkg::req_t r);
		plids_pkg::rsp_t res;
		int pos;
		int j;
		res = '0;
		pos = int'(r.position);
		case (r.req_type)
			plids_pkg::REQ_INSERT: begin
				if (pos >= 1 && pos <= held_count + 1 && held_count < LIST_CAP) begin
					for (j = held_count; j >= pos; j--)
						held_entries[j] = held_entries[j - 1];
					held_entries[pos - 1] = r.value;
					held_count++;
					res.ok = 1'b1;
				end
			end
			plids_pkg::REQ_DELETE: begin
				if (pos >= 1 && pos <= held_count) begin
					for (j = pos; j < held_count; j++)
						held_entries[j - 1] = held_entries[j];
					held_count--;
					res.ok = 1'b1;
				end
			end
			plids_pkg::REQ_LOCATE: begin
				for (j = 0; j < held_count; j++) begin
					if (held_entries[j] == r.value) begin
						res.ok = 1'b1;
						res.found_position = 8'(j + 1);
						break;
					end
				end
			end
			default: ;
		endcase
		res.list_length = 8'(held_count);
		return res;
	endfunction

	// Pick a random request. The mix leans toward inserts while the list is
	// growing and toward deletes while it drains, so it reaches both ends.
	function automatic plids_pkg::req_t next_random_request();
		plids_pkg::req_t r;
		int roll;
		int ins_pct;
		int del_pct;
		if (held_count == LIST_CAP && $urandom_range(0, 3) == 0)
			growing = 1'b0;
		else if (held_count == 0 && $urandom_range(0, 3) == 0)
			growing = 1'b1;
		ins_pct = growing ? 65 : 12;
		del_pct = growing ? 12 : 65;
		roll = $urandom_range(0, 99);
		r.position = 8'($urandom_range(0, 255));
		// A small pool of values makes duplicates common.
		r.value = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
		if (roll < ins_pct) begin
			r.req_type = plids_pkg::REQ_INSERT;
			if ($urandom_range(0, 9) == 0)
				r.position = ($urandom_range(0, 1) == 0) ? 8'd0
					: 8'($urandom_range(held_count + 2, 255));
			else
				r.position = 8'($urandom_range(1, held_count + 1));
		end else if (roll < ins_pct + del_pct) begin
			r.req_type = plids_pkg::REQ_DELETE;
			if (held_count == 0 || $urandom_range(0, 9) == 0)
				r.position = ($urandom_range(0, 1) == 0) ? 8'd0
					: 8'($urandom_range(held_count + 1, 255));
			else
				r.position = 8'($urandom_range(1, held_count));
		end else if (roll < ins_pct + del_pct + 18) begin
			r.req_type = plids_pkg::REQ_LOCATE;
			if (held_count > 0 && $urandom_range(0, 9) < 6)
				r.value = held_entries[$urandom_range(0, held_count - 1)];
		end else begin
			r.req_type = REQ_UNUSED;
		end
		return r;
	endfunction

	// Offer one request, wait for its transfer and record the expected result.
	task automatic send_request(input plids_pkg::req_t item, input logic typed,
		input plids_pkg::rsp_t want);
		plids_pkg::rsp_t predicted;
		if (!steady_window() && $urandom_range(0, 99) < 8) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while (!steady_window() && $urandom_range(0, 99) < 8);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (req_stall);
		predicted = apply_request(item);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Reset, directed table, random requests, then drain and report.
	initial begin : stimulus
		int i;
		int issued;
		int waited;
		plids_pkg::req_t item;
		held_count = 0;
		growing = 1'b1;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(DIRECTED_ROWS); i++)
			send_request(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].want);

		// Requests with the unused code do not count toward the total.
		issued = 0;
		while (issued < RANDOM_REQUESTS) begin
			item = next_random_request();
			if (item.req_type != REQ_UNUSED)
				issued++;
			send_request(item, PREDICT, '0);
		end
		req_valid <= 1'b0;

		waited = 0;
		while (pending_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			$error("%0d expected results never arrived", pending_results.size());
		if (errors == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Result receiver: random stalls, plus two long hold-offs that let the
	// block back up and stall its request side.
	initial begin : receiver
		int hold_left;
		int own_cycles;
		hold_left = 0;
		own_cycles = 0;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			own_cycles++;
			if (own_cycles == 1800 || own_cycles == 4500)
				hold_left = 250;
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= !steady_window() && ($urandom_range(0, 99) < 8);
			end
		end
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin : check_results
		plids_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("Result with no request pending: ok=%0d found_position=%0d list_length=%0d",
					rsp.ok, rsp.found_position, rsp.list_length);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, rsp.ok);
					errors++;
				end
				if (rsp.found_position !== want.found_position) begin
					$error("found_position: expected %0d, got %0d",
						want.found_position, rsp.found_position);
					errors++;
				end
				if (rsp.list_length !== want.list_length) begin
					$error("list_length: expected %0d, got %0d",
						want.list_length, rsp.list_length);
					errors++;
				end
			end
		end
	end

	// Guard against a hung handshake.
	initial begin : watchdog
		#1ms;
		$display("Verification failed");
		$finish;
	end

endmodule
